// ----- hw/rtl/zflscan_pkg.sv -----
// shared types, constants and lookup functions of the zstd frame length scanner
// no dependencies; imported by the scanner unit and its checker
`default_nettype none

package zflscan_pkg;

    // width of the frame length counter (16 to 64)
    localparam int LENGTH_BITS = 32;

    // result field width
    localparam int FRAME_LENGTH_W = 32;

    // largest counter value, masked to the result width
    localparam logic [63:0] LEN_MAX_WIDE = {64{1'b1}} >> (64 - LENGTH_BITS);
    localparam logic [FRAME_LENGTH_W-1:0] LEN_MAX_OUT = LEN_MAX_WIDE[FRAME_LENGTH_W-1:0];

    // field sizes in bytes
    localparam logic [3:0] BLKHDR_BYTES   = 4'd3;
    localparam logic [3:0] CHECKSUM_BYTES = 4'd4;

    // block types
    localparam logic [1:0] BLK_TYPE_RLE      = 2'd1;
    localparam logic [1:0] BLK_TYPE_RESERVED = 2'd3;

    // frame magic, little-endian order on the wire
    localparam logic [7:0] MAGIC_B0 = 8'h28;
    localparam logic [7:0] MAGIC_B1 = 8'hB5;
    localparam logic [7:0] MAGIC_B2 = 8'h2F;
    localparam logic [7:0] MAGIC_B3 = 8'hFD;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MAGIC,
        PH_DESC,
        PH_HDRSKIP,
        PH_BLKHDR,
        PH_CONTENT,
        PH_CHECKSUM
    } phase_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_BADMAGIC = 2'd1,
        ST_RESERVED = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = MAGIC_B0;
            2'd1:    val = MAGIC_B1;
            2'd2:    val = MAGIC_B2;
            default: val = MAGIC_B3;
        endcase
        return val;
    endfunction

    // dictionary id field size from descriptor bits 1:0
    function automatic logic [3:0] did_size(input logic [1:0] code);
        logic [3:0] val;
        case (code)
            2'd0:    val = 4'd0;
            2'd1:    val = 4'd1;
            2'd2:    val = 4'd2;
            default: val = 4'd4;
        endcase
        return val;
    endfunction

    // frame content size field size from descriptor bits 7:6
    function automatic logic [3:0] fcs_size(input logic [1:0] code);
        logic [3:0] val;
        case (code)
            2'd0:    val = 4'd0;
            2'd1:    val = 4'd2;
            2'd2:    val = 4'd4;
            default: val = 4'd8;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/zstd_frame_length_scanner_unit.sv -----
// top level of the zstd frame length scanner: byte parser, counters, result skid
// depends on zflscan_pkg
`default_nettype none

// Scans a byte stream, one item (one byte) per cycle while in_stall is low, and
// measures one Zstandard frame that starts at a byte with frame_start set. The
// 4-byte magic is checked, the frame header descriptor is decoded and the window,
// dictionary id and content size fields are skipped; then the 3-byte block headers
// are walked, each block's content is skipped (an RLE block holds one byte) and the
// optional 4-byte checksum is skipped. One result item gives the frame length and
// a status: complete, bad magic, reserved block type or length counter overflow. A
// frame_start inside a frame drops the frame in progress without a result; bytes
// outside a frame are ignored. The phase and the small counters are updated in the
// cycle the byte is accepted and a result goes straight into the output
// register. Behind that register sits a one-entry skid register, so input is taken
// every cycle while a result waits; in_stall rises only while the skid register is
// full, that is after a second result came in while out_stall held the first.
// There is no clearing pass after reset.
module zstd_frame_length_scanner_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      frame_length,
    output logic [1:0]       status
);
    import zflscan_pkg::*;

    localparam int LW = LENGTH_BITS;

    // parser state
    phase_t           phase_reg, phase_next;
    logic [3:0]       fbl_reg, fbl_next;        // magic index, or bytes left of a header field or the checksum
    logic [20:0]      content_reg, content_next; // block content bytes left
    logic [LW-1:0]    len_reg, len_next;        // bytes of the current frame
    logic             chk_reg, chk_next;        // descriptor asks for a checksum
    logic             last_reg, last_next;      // current block is the last one
    logic [15:0]      hdr_reg, hdr_next;        // first two block header bytes

    // output register and skid register
    logic                      out_valid_reg;
    logic [FRAME_LENGTH_W-1:0] out_len_reg;
    status_t                   out_status_reg;
    logic                      skid_valid_reg;
    logic [FRAME_LENGTH_W-1:0] skid_len_reg;
    status_t                   skid_status_reg;

    // result of the current item
    logic                      emit;
    status_t                   res_status;
    logic [LW-1:0]             res_cnt;
    logic [63:0]               res_wide;
    logic [FRAME_LENGTH_W-1:0] res_len;

    logic          accept;
    logic          out_fire;
    logic          len_full;
    logic [LW-1:0] len_inc;

    // block header decode on its third byte
    logic [23:0]   hdr_full;
    logic [1:0]    hdr_type;
    logic [20:0]   content_new;
    logic [20:0]   content_dec;
    logic [3:0]    fbl_dec;

    // descriptor decode
    logic          desc_single;
    logic [1:0]    desc_fcs;
    logic [3:0]    desc_n;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    assign len_full = &len_reg;
    assign len_inc  = len_reg + LW'(1);

    assign hdr_full    = {data_byte, hdr_reg};
    assign hdr_type    = hdr_full[2:1];
    assign content_new = (hdr_type == BLK_TYPE_RLE) ? 21'd1 : hdr_full[23:3];
    assign content_dec = (content_reg != 21'd0) ? (content_reg - 21'd1) : 21'd0;
    assign fbl_dec     = (fbl_reg != 4'd0) ? (fbl_reg - 4'd1) : 4'd0;

    assign desc_single = data_byte[5];
    assign desc_fcs    = data_byte[7:6];
    assign desc_n      = (desc_single ? 4'd0 : 4'd1) + did_size(data_byte[1:0])
                       + ((desc_fcs == 2'd0) ? {3'd0, desc_single} : fcs_size(desc_fcs));

    // result decision: which item ends a frame and with what status
    always_comb
    begin
        emit       = 1'b0;
        res_status = ST_DONE;
        res_cnt    = len_inc;
        if (accept) begin
            if (frame_start) begin
                res_cnt = LW'(1);
                if (data_byte != MAGIC_B0) begin
                    emit       = 1'b1;
                    res_status = ST_BADMAGIC;
                end
            end else if (phase_reg != PH_IDLE) begin
                if (len_full) begin
                    // counter saturated: report the maximum
                    emit       = 1'b1;
                    res_status = ST_OVERFLOW;
                    res_cnt    = len_reg;
                end else begin
                    case (phase_reg)
                        PH_MAGIC:
                        begin
                            if (data_byte != magic_byte(fbl_reg[1:0])) begin
                                emit       = 1'b1;
                                res_status = ST_BADMAGIC;
                            end
                        end
                        PH_BLKHDR:
                        begin
                            if (fbl_reg != BLKHDR_BYTES && fbl_reg != 4'd2) begin
                                if (hdr_type == BLK_TYPE_RESERVED) begin
                                    emit       = 1'b1;
                                    res_status = ST_RESERVED;
                                end else if (content_new == 21'd0 && hdr_full[0] &&
                                             !chk_reg) begin
                                    // empty last block and no checksum
                                    emit = 1'b1;
                                end
                            end
                        end
                        PH_CONTENT:
                        begin
                            if (content_dec == 21'd0 && last_reg && !chk_reg) begin
                                emit = 1'b1;
                            end
                        end
                        PH_CHECKSUM:
                        begin
                            if (fbl_dec == 4'd0) begin
                                emit = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    assign res_wide = 64'(res_cnt);
    assign res_len  = res_wide[FRAME_LENGTH_W-1:0];

    // parser next state
    always_comb
    begin
        phase_next   = phase_reg;
        fbl_next     = fbl_reg;
        content_next = content_reg;
        len_next     = len_reg;
        chk_next     = chk_reg;
        last_next    = last_reg;
        hdr_next     = hdr_reg;
        if (accept) begin
            if (frame_start) begin
                len_next   = LW'(1);
                chk_next   = 1'b0;
                last_next  = 1'b0;
                hdr_next   = 16'd0;
                phase_next = PH_MAGIC;
                fbl_next   = 4'd1;
            end else if (phase_reg != PH_IDLE && !len_full) begin
                len_next = len_inc;
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        fbl_next = fbl_reg + 4'd1;
                        if (fbl_reg == 4'd3) begin
                            phase_next = PH_DESC;
                            fbl_next   = 4'd0;
                        end
                    end
                    PH_DESC:
                    begin
                        chk_next = data_byte[2];
                        if (desc_n == 4'd0) begin
                            phase_next = PH_BLKHDR;
                            fbl_next   = BLKHDR_BYTES;
                        end else begin
                            phase_next = PH_HDRSKIP;
                            fbl_next   = desc_n;
                        end
                    end
                    PH_HDRSKIP:
                    begin
                        fbl_next = fbl_dec;
                        if (fbl_dec == 4'd0) begin
                            phase_next = PH_BLKHDR;
                            fbl_next   = BLKHDR_BYTES;
                        end
                    end
                    PH_BLKHDR:
                    begin
                        if (fbl_reg == BLKHDR_BYTES) begin
                            hdr_next = {8'd0, data_byte};
                            fbl_next = 4'd2;
                        end else if (fbl_reg == 4'd2) begin
                            hdr_next = {data_byte, hdr_reg[7:0]};
                            fbl_next = 4'd1;
                        end else begin
                            last_next    = hdr_full[0];
                            fbl_next     = 4'd0;
                            content_next = content_new;
                            if (content_new != 21'd0) begin
                                phase_next = PH_CONTENT;
                            end else if (!hdr_full[0]) begin
                                phase_next = PH_BLKHDR;
                                fbl_next   = BLKHDR_BYTES;
                            end else if (chk_reg) begin
                                phase_next = PH_CHECKSUM;
                                fbl_next   = CHECKSUM_BYTES;
                            end
                        end
                    end
                    PH_CONTENT:
                    begin
                        content_next = content_dec;
                        if (content_dec == 21'd0) begin
                            if (!last_reg) begin
                                phase_next = PH_BLKHDR;
                                fbl_next   = BLKHDR_BYTES;
                            end else if (chk_reg) begin
                                phase_next = PH_CHECKSUM;
                                fbl_next   = CHECKSUM_BYTES;
                            end
                        end
                    end
                    PH_CHECKSUM:
                    begin
                        fbl_next = fbl_dec;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            // any result closes the frame
            if (emit) begin
                phase_next   = PH_IDLE;
                fbl_next     = 4'd0;
                content_next = 21'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_IDLE;
            fbl_reg     <= 4'd0;
            content_reg <= 21'd0;
            len_reg     <= '0;
            chk_reg     <= 1'b0;
            last_reg    <= 1'b0;
            hdr_reg     <= 16'd0;
        end else begin
            phase_reg   <= phase_next;
            fbl_reg     <= fbl_next;
            content_reg <= content_next;
            len_reg     <= len_next;
            chk_reg     <= chk_next;
            last_reg    <= last_next;
            hdr_reg     <= hdr_next;
        end
    end

    // output register with skid: a result that finds the output register held
    // waits in the skid register, which stalls the input until it moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (out_fire) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (emit) begin
                if (!out_valid_reg || out_fire) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_fire) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_len_reg    <= skid_len_reg;
                out_status_reg <= skid_status_reg;
            end
        end else if (emit) begin
            if (!out_valid_reg || out_fire) begin
                out_len_reg    <= res_len;
                out_status_reg <= res_status;
            end else begin
                skid_len_reg    <= res_len;
                skid_status_reg <= res_status;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_length = out_len_reg;
    assign status       = out_status_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/zflscan_checker.sv -----
// port-level checker for the zstd frame length scanner, with its bind
// depends on zflscan_pkg and zstd_frame_length_scanner_unit
`default_nettype none

module zflscan_assertions (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [7:0]  data_byte,
    input wire logic        frame_start,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] frame_length,
    input wire logic [1:0]  status
);
    import zflscan_pkg::*;

    // an overflowed frame reports the saturated counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OVERFLOW) |-> frame_length == LEN_MAX_OUT)
    else $error("overflow result without saturated length");

    // bad magic is found within the first four bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_BADMAGIC) |->
        (frame_length != 32'd0 && frame_length <= 32'd4))
    else $error("bad magic result with impossible length");

    // the skid register is empty in the cycle after the output moves
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && !out_stall) |=> !in_stall)
    else $error("input stall held after output was taken");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(frame_length) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind zstd_frame_length_scanner_unit zflscan_assertions u_zflscan_assertions (.*);

`default_nettype wire
